FILE: src/thermistor_temperature_linearizer_top_defines.svh
// Assertion macros shared by the linearizer RTL.
`ifndef THERMISTOR_TEMPERATURE_LINEARIZER_TOP_DEFINES_SVH
`define THERMISTOR_TEMPERATURE_LINEARIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define TTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ttl_pkg.sv
package ttl_pkg;

  localparam int unsigned TABLE_POINTS = 24;
  localparam int unsigned IDX_W        = $clog2(TABLE_POINTS);
  localparam int unsigned TEMP_W       = 11;
  localparam int unsigned DIFF_W       = 7;   // width of the step between table temperatures
  localparam int unsigned SER_W        = 16;
  localparam int unsigned NOM_W        = 16;
  localparam int unsigned SUP_W        = 17;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY  = 2'd2;

  // register reset values
  localparam logic [SER_W-1:0] SER_RST = 16'd10000;
  localparam logic [NOM_W-1:0] NOM_RST = 16'd10000;
  localparam logic [SUP_W-1:0] SUP_RST = 17'd65610;

  typedef enum logic [1:0] {
    ST_IN_TABLE = 2'd0,
    ST_HOT      = 2'd1,
    ST_COLD     = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  // per-item control carried alongside the interpolation data
  typedef struct packed {
    logic                     interp;
    status_e                  status;
    logic signed [TEMP_W-1:0] temp;    // final value, or base point when interp
  } seg_ctl_t;

  // resistance ratio against 25 C, units of 1/10000
  localparam logic [19:0] RATIO_E4 [TABLE_POINTS] = '{
    20'd2488,   20'd2986,   20'd3603,   20'd4369,   20'd5327,   20'd6531,
    20'd8057,   20'd10000,  20'd12490,  20'd15710,  20'd19900,  20'd25390,
    20'd32650,  20'd42320,  20'd55330,  20'd72930,  20'd97070,  20'd130400,
    20'd177000, 20'd242600, 20'd336500, 20'd471700, 20'd670100, 20'd963000
  };

  localparam logic signed [TEMP_W-1:0] TEMP_TBL [TABLE_POINTS] = '{
    11'sd600,  11'sd550,  11'sd500,  11'sd450,  11'sd400,  11'sd350,
    11'sd300,  11'sd250,  11'sd200,  11'sd150,  11'sd100,  11'sd50,
    11'sd0,    -11'sd50,  -11'sd100, -11'sd150, -11'sd200, -11'sd250,
    -11'sd300, -11'sd350, -11'sd400, -11'sd450, -11'sd500, -11'sd550
  };

  // table ratio in fixed point, rounded half up; elaboration only
  function automatic logic [63:0] tbl_q(input int unsigned idx, input int unsigned frac);
    return ((64'(RATIO_E4[idx]) << frac) + 64'd5000) / 64'd10000;
  endfunction

endpackage

FILE: src/ttl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// num_i is the dividend zero-extended to DW+QW bits; its top DW bits must
// be below den_i. The sideband travels with the item.
module ttl_div #(
  parameter int unsigned DW = 17,
  parameter int unsigned QW = 32,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quot_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned AW = DW + QW;

  logic [QW-1:0] vld_q;
  logic [AW-1:0] acc_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [AW-1:0] acc_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [DW:0]   part;
    logic [DW:0]   diffv;
    logic          take;

    if (s == 0) begin : g_first
      assign acc_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign acc_in  = acc_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // trial subtract of the shifted partial remainder
    assign part  = acc_in[AW-1:QW-1];
    assign take  = (part >= {1'b0, den_in});
    assign diffv = part - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[s]  <= {(take ? diffv[DW-1:0] : part[DW-1:0]), acc_in[QW-2:0], take};
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = acc_q[QW-1][QW-1:0];
  assign side_o  = side_q[QW-1];

endmodule

FILE: src/ttl_seg.sv
// Table search and segment selection, two stages:
// compare the ratio against every table point, then pick the segment.
module ttl_seg import ttl_pkg::*; #(
  parameter int unsigned RATIO_FRAC_BITS = 16,
  parameter int unsigned QW              = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [QW-1:0]              ratio_i,
  input  logic                       inv_i,
  output logic                       valid_o,
  output seg_ctl_t                   ctl_o,
  output logic [RATIO_FRAC_BITS+6:0] qe_o,    // ratio above lower point
  output logic [RATIO_FRAC_BITS+6:0] den_o,   // segment width
  output logic [DIFF_W-1:0]          diff_o   // temperature step of the segment
);

  localparam int unsigned TQW = RATIO_FRAC_BITS + 7;

  logic [TQW-1:0] tq [TABLE_POINTS];

  for (genvar i = 0; i < TABLE_POINTS; i++) begin : g_tbl
    localparam logic [TQW-1:0] TQ_C = TQW'(tbl_q(i, RATIO_FRAC_BITS));
    assign tq[i] = TQ_C;
  end

  // compare stage
  logic [TABLE_POINTS-1:0] ge_d, ge_q;
  logic [TQW-1:0]          q_q;
  logic                    inv_q, c_vld_q;

  always_comb begin
    for (int i = 0; i < TABLE_POINTS; i++) begin
      ge_d[i] = (QW'(tq[i]) >= ratio_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ge_q  <= ge_d;
    q_q   <= ratio_i[TQW-1:0];
    inv_q <= inv_i;
  end

  // segment stage
  logic [IDX_W-1:0]  idx, idx_m1;
  logic              any_ge;
  seg_ctl_t          ctl_d, ctl_q;
  logic [TQW-1:0]    qe_d, qe_q, den_d, den_q;
  logic [TEMP_W-1:0] step;
  logic [DIFF_W-1:0] diff_d, diff_q;
  logic              s_vld_q;

  always_comb begin
    idx = IDX_W'(TABLE_POINTS - 1);
    for (int i = TABLE_POINTS - 1; i >= 0; i--) begin
      if (ge_q[i]) begin
        idx = IDX_W'(i);
      end
    end
    any_ge = |ge_q;
    idx_m1 = (idx == '0) ? '0 : idx - 1'b1;

    qe_d   = q_q - tq[idx_m1];
    den_d  = tq[idx] - tq[idx_m1];
    step   = TEMP_TBL[idx_m1] - TEMP_TBL[idx];
    diff_d = step[DIFF_W-1:0];

    ctl_d.interp = 1'b0;
    ctl_d.status = ST_IN_TABLE;
    ctl_d.temp   = TEMP_TBL[idx];
    if (inv_q) begin
      ctl_d.status = ST_INVALID;
      ctl_d.temp   = '0;
    end else if (!any_ge) begin
      ctl_d.status = ST_COLD;
      ctl_d.temp   = TEMP_TBL[TABLE_POINTS-1];
    end else if (q_q == tq[idx]) begin
      ctl_d.status = ST_IN_TABLE;
    end else if (idx == '0) begin
      ctl_d.status = ST_HOT;
    end else begin
      ctl_d.interp = 1'b1;
      ctl_d.temp   = TEMP_TBL[idx_m1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q  <= ctl_d;
    qe_q   <= qe_d;
    den_q  <= den_d;
    diff_q <= diff_d;
  end

  assign valid_o = s_vld_q;
  assign ctl_o   = ctl_q;
  assign qe_o    = qe_q;
  assign den_o   = den_q;
  assign diff_o  = diff_q;

endmodule

FILE: src/thermistor_temperature_linearizer_top.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// sample   | start_i, busy_o           | adc_code_i
// result   | done_o (one-cycle strobe) | temperature_tenths_o, range_status_o
// config   | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item per cycle in, one result per item out, in order.
// The path holds three bit-per-stage dividers: resistance, ratio, interpolation.
// busy_o is always low; config and result ports never wait either.
// Reset clears the stage valid bits and loads the register reset values.
`include "thermistor_temperature_linearizer_top_defines.svh"

module thermistor_temperature_linearizer_top import ttl_pkg::*; #(
  parameter int unsigned ADC_BITS        = 12,
  parameter int unsigned RATIO_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [ADC_BITS-1:0]      adc_code_i,
  output logic                     done_o,
  output logic signed [TEMP_W-1:0] temperature_tenths_o,
  output logic [1:0]               range_status_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned CW  = ADC_BITS + 4;            // code times sixteen
  localparam int unsigned XW  = (CW > SUP_W) ? CW : SUP_W;
  localparam int unsigned RW  = SER_W + CW;              // resistance width
  localparam int unsigned QW  = RW + RATIO_FRAC_BITS;    // ratio width
  localparam int unsigned TQW = RATIO_FRAC_BITS + 7;
  localparam int unsigned NW3 = TQW + DIFF_W + 1;
  localparam int unsigned CTW = $bits(seg_ctl_t);

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  logic [SER_W-1:0] ser_q;
  logic [NOM_W-1:0] nom_q;
  logic [SUP_W-1:0] sup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_q <= SER_RST;
      nom_q <= NOM_RST;
      sup_q <= SUP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SERIES:  ser_q <= cfg_data_i[SER_W-1:0];
        CFG_NOMINAL: nom_q <= cfg_data_i[NOM_W-1:0];
        CFG_SUPPLY:  sup_q <= cfg_data_i[SUP_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage: divider numerator, denominator and invalid check
  logic [CW-1:0]    code16;
  logic             a_vld_q, a_inv_q;
  logic [RW-1:0]    a_prod_q;
  logic [SUP_W-1:0] a_den_q;
  logic [XW-1:0]    sub_full;

  assign code16   = {adc_code_i, 4'b0000};
  assign sub_full = XW'(sup_q) - XW'(code16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_inv_q  <= (XW'(code16) >= XW'(sup_q));
    a_prod_q <= ser_q * code16;
    a_den_q  <= sub_full[SUP_W-1:0];
  end

  // resistance in ohms
  logic          r_vld, r_inv;
  logic [RW-1:0] r_ohm;

  ttl_div #(.DW(SUP_W), .QW(RW), .SW(1)) u_div_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_vld_q),
    .num_i   ((SUP_W + RW)'(a_prod_q)),
    .den_i   (a_den_q),
    .side_i  (a_inv_q),
    .valid_o (r_vld),
    .quot_o  (r_ohm),
    .side_o  (r_inv)
  );

  // ratio against the nominal resistance
  logic             q_vld, q_inv;
  logic [QW-1:0]    q_ratio;
  logic [NOM_W-1:0] nom_safe;

  assign nom_safe = (nom_q == '0) ? NOM_W'(1) : nom_q;

  ttl_div #(.DW(NOM_W), .QW(QW), .SW(1)) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_vld),
    .num_i   ((NOM_W + QW)'({r_ohm, {RATIO_FRAC_BITS{1'b0}}})),
    .den_i   (nom_safe),
    .side_i  (r_inv),
    .valid_o (q_vld),
    .quot_o  (q_ratio),
    .side_o  (q_inv)
  );

  // table search
  logic              s_vld;
  seg_ctl_t          s_ctl;
  logic [TQW-1:0]    s_qe, s_den;
  logic [DIFF_W-1:0] s_diff;

  ttl_seg #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS), .QW(QW)) u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_vld),
    .ratio_i (q_ratio),
    .inv_i   (q_inv),
    .valid_o (s_vld),
    .ctl_o   (s_ctl),
    .qe_o    (s_qe),
    .den_o   (s_den),
    .diff_o  (s_diff)
  );

  // interpolation product
  logic                  e_vld_q;
  seg_ctl_t              e_ctl_q;
  logic [TQW+DIFF_W-1:0] e_num_q;
  logic [TQW-1:0]        e_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    e_ctl_q <= s_ctl;
    e_num_q <= s_qe * s_diff;
    e_den_q <= s_den;
  end

  // rounding offset: (2*num + den - 1) / (2*den)
  logic           f_vld_q;
  seg_ctl_t       f_ctl_q;
  logic [NW3-1:0] f_n3_q;
  logic [TQW:0]   f_d3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_ctl_q <= e_ctl_q;
    f_n3_q  <= {e_num_q, 1'b0} + NW3'(e_den_q) - NW3'(1);
    f_d3_q  <= {e_den_q, 1'b0};
  end

  logic              i_vld;
  logic [DIFF_W-1:0] i_adj;
  logic [CTW-1:0]    i_side;
  seg_ctl_t          i_ctl;

  ttl_div #(.DW(TQW + 1), .QW(DIFF_W), .SW(CTW)) u_div_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld_q),
    .num_i   (f_n3_q),
    .den_i   (f_d3_q),
    .side_i  (f_ctl_q),
    .valid_o (i_vld),
    .quot_o  (i_adj),
    .side_o  (i_side)
  );

  assign i_ctl = seg_ctl_t'(i_side);

  // result register
  logic                     done_q;
  logic signed [TEMP_W-1:0] temp_d, temp_q;
  logic [1:0]               stat_q;

  assign temp_d = i_ctl.interp ? (i_ctl.temp - $signed(TEMP_W'(i_adj))) : i_ctl.temp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= i_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
    stat_q <= i_ctl.status;
  end

  assign done_o               = done_q;
  assign temperature_tenths_o = temp_q;
  assign range_status_o       = stat_q;

  `TTL_ASSERT_NOW(a_invalid_zero, done_o && (range_status_o == ST_INVALID), temperature_tenths_o == 11'sd0, "invalid code must give zero")
  `TTL_ASSERT_NOW(a_hot_clamp, done_o && (range_status_o == ST_HOT), temperature_tenths_o == 11'sd600, "hot clamp must give 60.0")
  `TTL_ASSERT_NOW(a_cold_clamp, done_o && (range_status_o == ST_COLD), temperature_tenths_o == -11'sd550, "cold clamp must give -55.0")
  `TTL_ASSERT_NOW(a_in_range, done_o && (range_status_o == ST_IN_TABLE), (temperature_tenths_o >= -11'sd550) && (temperature_tenths_o <= 11'sd600), "interpolated value out of table range")
  `TTL_ASSERT_NEXT(a_done_follows, i_vld, done_o, "result strobe lost")

endmodule

FILE: tb/testbench.sv
module testbench;
  import ttl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADC_W     = 12;
  localparam int unsigned FRAC      = 16;
  localparam int unsigned LATENCY   = 2 * (ADC_W + 20) + FRAC + 13;
  localparam int unsigned N_RANDOM  = 1500;
  localparam longint     CYCLE_CAP = 400000;

  // expected temperature and status of one sample
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    status_e                  status;
  } reading_t;

  // Linearizer prediction and queue of pending readings
  class reading_board;
    logic [SER_W-1:0] series;
    logic [NOM_W-1:0] nominal;
    logic [SUP_W-1:0] supply;
    reading_t         pending[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      status_seen[4];

    function new();
      series  = SER_RST;
      nominal = NOM_RST;
      supply  = SUP_RST;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SERIES:  series  = data[SER_W-1:0];
        CFG_NOMINAL: nominal = data[NOM_W-1:0];
        CFG_SUPPLY:  supply  = data[SUP_W-1:0];
        default: ;
      endcase
    endfunction

    // table ratio in Q16, rounded half up
    function longint unsigned ratio_point(int i);
      return ((longint'(RATIO_E4[i]) << FRAC) + 5000) / 10000;
    endfunction

    function reading_t convert(logic [ADC_W-1:0] code);
      reading_t         res;
      longint unsigned  code16, ohms, nom, q, hi, lo, span, num, adj;
      int               i;
      code16 = longint'(code) << 4;
      if (code16 >= supply) begin
        res.temp = '0; res.status = ST_INVALID; return res;
      end
      ohms = (longint'(series) * code16) / (supply - code16);
      nom  = (nominal == 0) ? 1 : nominal;
      q    = (ohms << FRAC) / nom;
      for (i = 0; i < TABLE_POINTS; i++)
        if (ratio_point(i) >= q) break;
      if (i == TABLE_POINTS) begin
        res.temp = TEMP_TBL[TABLE_POINTS-1]; res.status = ST_COLD; return res;
      end
      hi = ratio_point(i);
      if (hi == q) begin
        res.temp = TEMP_TBL[i]; res.status = ST_IN_TABLE; return res;
      end
      if (i == 0) begin
        res.temp = TEMP_TBL[0]; res.status = ST_HOT; return res;
      end
      lo   = ratio_point(i - 1);
      span = hi - lo;
      num  = (q - lo) * longint'(TEMP_TBL[i-1] - TEMP_TBL[i]);
      adj  = (2 * num + span - 1) / (2 * span);
      res.temp   = TEMP_TBL[i-1] - TEMP_W'(adj);
      res.status = ST_IN_TABLE;
      return res;
    endfunction

    function void note_sample(logic [ADC_W-1:0] code);
      pending.push_back(convert(code));
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_reading(logic signed [TEMP_W-1:0] temp, logic [1:0] status);
      reading_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected reading temp=%0d status=%0d", temp, status));
        return;
      end
      want = pending.pop_front();
      checked++;
      status_seen[status]++;
      if (temp !== want.temp)
        report($sformatf("temperature got %0d want %0d", temp, want.temp));
      if (status !== want.status)
        report($sformatf("status got %0d want %0d", status, want.status));
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [ADC_W-1:0]         adc_code_i;
  logic                     done_o;
  logic signed [TEMP_W-1:0] temperature_tenths_o;
  logic [1:0]               range_status_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  reading_board board;
  longint       cycles;
  bit           calm;

  thermistor_temperature_linearizer_top #(
    .ADC_BITS(ADC_W),
    .RATIO_FRAC_BITS(FRAC)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .adc_code_i(adc_code_i),
    .done_o(done_o),
    .temperature_tenths_o(temperature_tenths_o),
    .range_status_o(range_status_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      board.check_reading(temperature_tenths_o, range_status_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // drive one sample, with an optional random idle gap first
  task automatic send_sample(logic [ADC_W-1:0] code);
    while (!calm && $urandom_range(99) < 31) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    adc_code_i <= code;
    do @(posedge clk_i); while (busy_o);
    board.note_sample(code);
  endtask

  task automatic end_samples();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every pending reading, then the pipeline depth again
  task automatic drain();
    end_samples();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  task automatic set_regs(int unsigned ser, int unsigned nom, int unsigned sup);
    write_reg(CFG_SERIES, CFG_DATA_W'(ser));
    write_reg(CFG_NOMINAL, CFG_DATA_W'(nom));
    write_reg(CFG_SUPPLY, CFG_DATA_W'(sup));
    cfg_valid_i <= 1'b0;
  endtask

  // random phase mixing uniform codes with codes from the top, bottom and middle bands
  task automatic random_phase(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      calm = (k >= n / 3) && (k < n / 2);
      case ($urandom_range(3))
        0:       send_sample(ADC_W'($urandom));
        1:       send_sample(ADC_W'($urandom_range(4095, 3900)));
        2:       send_sample(ADC_W'($urandom_range(200, 0)));
        default: send_sample(ADC_W'($urandom_range(3000, 800)));
      endcase
    end
    calm = 1'b0;
  endtask

  initial begin
    reading_board b;
    int unsigned  phase_items;
    b = new();
    board       = b;
    cycles      = 0;
    calm        = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    adc_code_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SERIES;
    cfg_data_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, codes around mid-scale (ratio near 1.0), assorted codes
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd2050);
    send_sample(12'd2051);
    send_sample(12'd2052);
    send_sample(12'd4000);
    send_sample(12'd3900);
    send_sample(12'd600);
    send_sample(12'd3500);
    send_sample(12'hAAA);
    send_sample(12'h555);
    drain();

    // equal resistors, supply 4096*16: code 2048 gives exactly 25.0
    set_regs(10000, 10000, 65536);
    send_sample(12'd2048);
    send_sample(12'd2047);
    send_sample(12'd4095);
    send_sample(12'd0);
    drain();
    // zero nominal and series, minimum supply
    set_regs(0, 0, 16);
    send_sample(12'd0);
    send_sample(12'd1);
    send_sample(12'd0);
    drain();
    set_regs(65535, 0, 131071);
    send_sample(12'd4095);
    send_sample(12'd1);
    drain();

    // random phases over several register settings, extremes included
    phase_items = N_RANDOM / 5;
    set_regs(10000, 10000, 65610);
    random_phase(phase_items);
    drain();
    set_regs(65535, 1, 131071);
    random_phase(phase_items);
    drain();
    set_regs(1, 65535, 16);
    random_phase(phase_items);
    drain();
    set_regs(4700, 10000, 65536);
    random_phase(phase_items);
    drain();
    set_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(131071, 16));
    random_phase(phase_items);
    drain();

    $display("Covered %0d readings over directed and random register settings.",
             board.checked);
    $display("Status counts: in table %0d, hot %0d, cold %0d, invalid %0d",
             board.status_seen[0], board.status_seen[1],
             board.status_seen[2], board.status_seen[3]);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
